FILE: hdl/poc_pkg.sv
// Shared types, constants and helpers of the proximity obstacle classifier.
package poc_pkg;

    localparam int CHANNELS     = 8;
    localparam int CH_BITS      = 3;
    localparam int OFFSET_BITS  = 6;
    localparam int SIDE_BITS    = 2;
    localparam int LEVEL_BITS   = 8;
    localparam int CFG_IDX_BITS = 2;
    localparam int SUM_BITS     = 22;
    localparam int OUT_BITS     = 48;
    localparam int FILT_NUM     = 14;
    localparam int FILT_SHIFT   = 4;

    typedef logic [CH_BITS-1:0]      t_chan;
    typedef logic [LEVEL_BITS-1:0]   t_level;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    typedef logic [OFFSET_BITS-1:0]  t_offset;
    typedef logic [SIDE_BITS-1:0]    t_side;
    typedef logic [1:0]              t_count;
    typedef logic [SUM_BITS-1:0]     t_sum;

    // Which band a filtered value falls in
    typedef struct packed {
        logic obstacle;
        logic side_band;
        logic below_clear;
    } t_band;

    localparam t_chan CH_CENTER  = 3'd0;
    localparam t_chan CH_FRONT_L = 3'd1;
    localparam t_chan CH_SIDE_L2 = 3'd2;
    localparam t_chan CH_SIDE_L3 = 3'd3;
    localparam t_chan CH_SIDE_R5 = 3'd5;
    localparam t_chan CH_SIDE_R6 = 3'd6;
    localparam t_chan CH_FRONT_R = 3'd7;

    localparam t_cfg_idx CFG_NOISE  = 2'd0;
    localparam t_cfg_idx CFG_MARGIN = 2'd1;
    localparam t_cfg_idx CFG_CLEAR  = 2'd2;

    localparam t_level NOISE_RESET  = 8'd50;
    localparam t_level MARGIN_RESET = 8'd10;
    localparam t_level CLEAR_RESET  = 8'd5;

    localparam t_side  SIDE_RIGHT = 2'b01;
    localparam t_count QUIET_FULL = 2'd2;
    localparam t_count COUNT_MAX  = 2'd3;

    function automatic t_count sat_inc(input t_count v);
        return (v == COUNT_MAX) ? v : v + 2'd1;
    endfunction

endpackage

FILE: hdl/poc_state_mem.sv
// Per-channel state memory with registered read, valid bits and write bypass.
module poc_state_mem #(
    parameter int DW = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  poc_pkg::t_chan    i_rd_addr,
    input  logic              i_wr_en,
    input  poc_pkg::t_chan    i_wr_addr,
    input  logic [DW-1:0]     i_wr_data,
    output logic [DW-1:0]     o_rd_data
);
    import poc_pkg::*;

    logic [DW-1:0]       r_mem [CHANNELS];
    logic [DW-1:0]       r_rd_data;
    logic [DW-1:0]       r_byp_data;
    logic [CHANNELS-1:0] r_valid;
    logic                r_rd_valid;
    logic                r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // Entries never written read as zero; a write in the read cycle wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
                r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_data = r_byp      ? r_byp_data :
                       r_rd_valid ? r_rd_data  : '0;

endmodule

FILE: hdl/poc_chan_update.sv
// Smoothing filter step and band classification of one channel sample.
module poc_chan_update #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic [SAMPLE_BITS+FRAC_BITS-1:0] i_filt,
    input  logic [SAMPLE_BITS-1:0]           i_prev,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  poc_pkg::t_offset                 i_offset,
    input  poc_pkg::t_level                  i_noise,
    input  poc_pkg::t_level                  i_margin,
    input  poc_pkg::t_level                  i_clear,
    output logic [SAMPLE_BITS+FRAC_BITS-1:0] o_y,
    output poc_pkg::t_band                   o_band
);
    import poc_pkg::*;

    localparam int W  = SAMPLE_BITS + FRAC_BITS;
    localparam int SW = W + 5;
    localparam int CW = W + 2;

    logic [SW-1:0]        acc;
    logic signed [CW-1:0] s_noise;
    logic signed [CW-1:0] s_off;
    logic signed [CW-1:0] s_margin;
    logic signed [CW-1:0] s_det_thr;
    logic signed [CW-1:0] s_side_thr;
    logic signed [CW-1:0] s_y;
    logic [W-1:0]         clear_thr;

    assign acc = SW'(FILT_NUM) * SW'(i_filt)
               + (SW'(i_sample) << FRAC_BITS)
               + (SW'(i_prev) << FRAC_BITS);
    assign o_y = W'(acc >> FILT_SHIFT);

    // Thresholds may go negative, so compare signed
    assign s_noise    = CW'(i_noise);
    assign s_off      = CW'(i_offset);
    assign s_margin   = CW'(i_margin);
    assign s_det_thr  = (s_noise - s_off) <<< FRAC_BITS;
    assign s_side_thr = (s_noise - s_margin) <<< FRAC_BITS;
    assign s_y        = CW'(o_y);
    assign clear_thr  = W'(i_clear) << FRAC_BITS;

    assign o_band.obstacle    = s_y > s_det_thr;
    assign o_band.side_band   = s_y > s_side_thr;
    assign o_band.below_clear = o_y < clear_thr;

endmodule

FILE: hdl/proximity_obstacle_classifier.sv
// Top level of the proximity obstacle classifier: scan control, flags, sums, output.
// Takes one proximity sample per cycle, channels 0 to 7 in scan order, and returns
// one result each time channel 7 is processed. A sample is read from the per-channel
// state memory at the edge it is accepted, then filtered, classified and written back
// when its stage commits, which a channel-7 stall can delay; a channel-7 result is
// registered in the output register. A same-channel sample accepted at the write-back is
// served by the write bypass. The input accepts a request every cycle, except that a
// channel-7 sample that finds the previous result not yet taken holds the input until the
// cycle after that result is taken. Forward and lateral sums are kept as running totals
// updated per sample. The eight memory entries read as zero after reset via valid bits,
// with no clearing pass. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must do so only while no request is in flight; the block does not enforce it.
module proximity_obstacle_classifier #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // channel, sample, detect_offset, side, clear_side (lowest bit up)
    input  logic [((SAMPLE_BITS + 12 + 7) / 8) * 8 - 1:0] i_s_tdata,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // obstacle_ahead, side_obstacle, turn_right, forward_sum, lateral_sum (lowest up)
    output logic [poc_pkg::OUT_BITS-1:0] o_m_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    input  logic                      i_cfg_we,
    input  poc_pkg::t_cfg_idx         i_cfg_idx,
    input  poc_pkg::t_level           i_cfg_data
);
    import poc_pkg::*;

    localparam int W        = SAMPLE_BITS + FRAC_BITS;
    localparam int DW       = 2 * W + SAMPLE_BITS;
    localparam int SMP_LSB  = CH_BITS;
    localparam int OFF_LSB  = SMP_LSB + SAMPLE_BITS;
    localparam int SIDE_LSB = OFF_LSB + OFFSET_BITS;
    localparam int CLR_BIT  = SIDE_LSB + SIDE_BITS;
    localparam int PAD_BITS = OUT_BITS - 3 - 2 * SUM_BITS;

    // configuration
    t_level r_noise;
    t_level r_margin;
    t_level r_clear;

    // filter stage
    logic                   r_s1_vld;
    t_chan                  r_s1_ch;
    logic [SAMPLE_BITS-1:0] r_s1_x;
    t_offset                r_s1_off;
    t_side                  r_s1_side;
    logic                   r_s1_clr;

    // scan state
    logic   r_ahead;
    logic   r_sflag;
    t_count r_fh;
    t_count r_lq;
    t_count r_rq;
    t_sum   r_fwd;
    t_sum   r_lat;
    logic [W-1:0] r_d1;
    logic [W-1:0] r_d7;

    logic                r_out_vld;
    logic [OUT_BITS-1:0] r_out_data;

    logic stall;
    logic accept;
    logic commit;
    logic last_ch;

    logic [DW-1:0]          rd_word;
    logic [DW-1:0]          wr_word;
    logic [W-1:0]           f_old;
    logic [SAMPLE_BITS-1:0] p_old;
    logic [W-1:0]           h_old;
    logic [W-1:0]           y;
    logic [W-1:0]           h_new;
    t_band                  band;

    logic   is_front;
    logic   is_side_ch;
    logic   is_left_q;
    logic   is_right_q;
    logic   front_hit;
    t_count fh0;
    t_count lq0;
    t_count rq0;
    logic   sf0;
    logic   ahead_mid;
    logic   sf_mid;
    t_count n_fh;
    t_count n_lq;
    t_count n_rq;
    logic   n_ahead;
    logic   n_sflag;
    logic   n_turn;

    t_sum fwd_old_t;
    t_sum fwd_new_t;
    t_sum half_old;
    t_sum half_new;
    t_sum lat_d;
    t_sum n_fwd;
    t_sum n_lat;

    // Hold the input while a scan-end sample waits for a full output register
    assign last_ch    = r_s1_ch == CH_FRONT_R;
    assign stall      = r_s1_vld && last_ch && r_out_vld;
    assign o_s_tready = !stall;
    assign accept     = i_s_tvalid && o_s_tready;
    assign commit     = r_s1_vld && !stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise  <= NOISE_RESET;
            r_margin <= MARGIN_RESET;
            r_clear  <= CLEAR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NOISE:  r_noise  <= i_cfg_data;
                CFG_MARGIN: r_margin <= i_cfg_data;
                CFG_CLEAR:  r_clear  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (!stall) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch   <= i_s_tdata[CH_BITS-1:0];
            r_s1_x    <= i_s_tdata[OFF_LSB-1:SMP_LSB];
            r_s1_off  <= i_s_tdata[SIDE_LSB-1:OFF_LSB];
            r_s1_side <= i_s_tdata[CLR_BIT-1:SIDE_LSB];
            r_s1_clr  <= i_s_tdata[CLR_BIT];
        end
    end

    poc_state_mem #(
        .DW (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (i_s_tdata[CH_BITS-1:0]),
        .i_wr_en   (commit),
        .i_wr_addr (r_s1_ch),
        .i_wr_data (wr_word),
        .o_rd_data (rd_word)
    );

    assign f_old   = rd_word[W-1:0];
    assign p_old   = rd_word[W+SAMPLE_BITS-1:W];
    assign h_old   = rd_word[DW-1:W+SAMPLE_BITS];
    assign wr_word = {h_new, r_s1_x, y};

    poc_chan_update #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_upd (
        .i_filt   (f_old),
        .i_prev   (p_old),
        .i_sample (r_s1_x),
        .i_offset (r_s1_off),
        .i_noise  (r_noise),
        .i_margin (r_margin),
        .i_clear  (r_clear),
        .o_y      (y),
        .o_band   (band)
    );

    always_comb begin
        is_front   = (r_s1_ch == CH_CENTER)
                  || ((r_s1_ch == CH_FRONT_L) && (r_s1_side != SIDE_RIGHT))
                  || ((r_s1_ch == CH_FRONT_R) && !r_s1_side[SIDE_BITS-1]);
        is_left_q  = (r_s1_ch == CH_SIDE_L2) || (r_s1_ch == CH_SIDE_L3);
        is_right_q = (r_s1_ch == CH_SIDE_R5) || (r_s1_ch == CH_SIDE_R6);
        is_side_ch = is_left_q || is_right_q;
        front_hit  = band.obstacle && is_front;

        // Scan start zeroes the counters before this sample counts
        fh0 = (r_s1_ch == CH_CENTER) ? '0 : r_fh;
        lq0 = (r_s1_ch == CH_CENTER) ? '0 : r_lq;
        rq0 = (r_s1_ch == CH_CENTER) ? '0 : r_rq;
        sf0 = r_s1_clr ? 1'b0 : r_sflag;

        h_new = band.below_clear ? '0 : (band.obstacle ? y : h_old);

        ahead_mid = front_hit ? 1'b1 : r_ahead;
        n_fh      = front_hit ? sat_inc(fh0) : fh0;
        sf_mid    = (!band.obstacle && band.side_band && is_side_ch) ? !r_ahead : sf0;
        n_rq      = (!band.obstacle && !band.side_band && is_right_q) ? sat_inc(rq0) : rq0;
        n_lq      = (!band.obstacle && !band.side_band && is_left_q) ? sat_inc(lq0) : lq0;

        n_ahead = ahead_mid;
        n_sflag = sf_mid;
        if (last_ch) begin
            if (n_fh == '0) n_ahead = 1'b0;
            if ((n_lq == QUIET_FULL) && (n_rq == QUIET_FULL)) n_sflag = 1'b0;
        end
        n_turn = r_d1 > h_new;
    end

    // Running sums: swap the old term of this channel for the new one
    always_comb begin
        half_old = SUM_BITS'(h_old >> 1);
        half_new = SUM_BITS'(h_new >> 1);
        priority if (r_s1_ch == CH_CENTER) begin
            fwd_old_t = SUM_BITS'(h_old);
            fwd_new_t = SUM_BITS'(h_new);
        end else if ((r_s1_ch == CH_FRONT_L) || (r_s1_ch == CH_FRONT_R)) begin
            fwd_old_t = half_old;
            fwd_new_t = half_new;
        end else begin
            fwd_old_t = '0;
            fwd_new_t = '0;
        end
        n_fwd = r_fwd + fwd_old_t - fwd_new_t;
        lat_d = half_new - half_old;
        priority if ((r_s1_ch == CH_FRONT_L) || is_left_q) begin
            n_lat = r_lat + lat_d;
        end else if ((r_s1_ch == CH_FRONT_R) || is_right_q) begin
            n_lat = r_lat - lat_d;
        end else begin
            n_lat = r_lat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ahead <= 1'b0;
            r_sflag <= 1'b0;
            r_fh    <= '0;
            r_lq    <= '0;
            r_rq    <= '0;
            r_fwd   <= '0;
            r_lat   <= '0;
            r_d1    <= '0;
            r_d7    <= '0;
        end else if (commit) begin
            r_ahead <= n_ahead;
            r_sflag <= n_sflag;
            r_fh    <= n_fh;
            r_lq    <= n_lq;
            r_rq    <= n_rq;
            r_fwd   <= n_fwd;
            r_lat   <= n_lat;
            if (r_s1_ch == CH_FRONT_L) r_d1 <= h_new;
            if (r_s1_ch == CH_FRONT_R) r_d7 <= h_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (commit && last_ch) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit && last_ch) begin
            r_out_data <= {{PAD_BITS{1'b0}}, n_lat, n_fwd, n_turn, n_sflag, n_ahead};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    a_result_from_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_s1_vld && last_ch))
        else $error("result appeared without a scan-end sample");

    a_ahead_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && last_ch |=> (!r_ahead || (r_fh != '0)))
        else $error("obstacle flag kept after a scan with no front hit");

    a_scan_start_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && (r_s1_ch == CH_CENTER) |=> (r_lq == '0) && (r_rq == '0)
            && (r_fh != COUNT_MAX))
        else $error("counters not restarted at scan start");

    a_d7_tracks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit && last_ch |=> r_d7 == $past(h_new))
        else $error("channel 7 distance copy out of step");

endmodule

FILE: tb/sv/proximity_obstacle_classifier_tb.sv
// Self-checking testbench for the proximity obstacle classifier.
`timescale 1ns / 100ps

module proximity_obstacle_classifier_tb;
    import poc_pkg::*;

    localparam int SAMPLE_W        = 12;
    localparam int FRAC            = 8;
    localparam int IN_W            = 24;
    localparam int N_PHASES        = 7;
    localparam int RANDOM_PER_PHASE = 270;
    localparam int HOLD_OFF_CYCLES = 300;

    // one input request, lowest field in the lowest bits
    typedef struct packed {
        logic                clear_side;
        t_side               side;
        t_offset             offset;
        logic [SAMPLE_W-1:0] raw;
        t_chan               channel;
    } t_sample;

    // one scan summary as it appears on the output bus
    typedef struct packed {
        logic pad;
        t_sum lateral;
        t_sum forward;
        logic turn_right;
        logic side_obs;
        logic ahead;
    } t_scan_result;

    class t_scan_scoreboard;
        logic [19:0]         smooth   [CHANNELS];
        logic [SAMPLE_W-1:0] last_raw [CHANNELS];
        logic [19:0]         held     [CHANNELS];
        bit                  ahead;
        bit                  side_seen;
        t_count              hits;
        t_count              left_q;
        t_count              right_q;
        t_level              noise;
        t_level              margin;
        t_level              clear_lvl;
        t_scan_result        expected_scans[$];
        int                  errors;
        int                  results_checked;

        function new();
            foreach (smooth[k]) begin
                smooth[k]   = '0;
                last_raw[k] = '0;
                held[k]     = '0;
            end
            ahead           = 1'b0;
            side_seen       = 1'b0;
            hits            = '0;
            left_q          = '0;
            right_q         = '0;
            noise           = NOISE_RESET;
            margin          = MARGIN_RESET;
            clear_lvl       = CLEAR_RESET;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void set_level(t_cfg_idx idx, t_level v);
            case (idx)
                CFG_NOISE:  noise = v;
                CFG_MARGIN: margin = v;
                CFG_CLEAR:  clear_lvl = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_scans.size();
        endfunction

        function void note_sample(t_sample s);
            t_chan        ch;
            int           sd;
            longint       y;
            longint       obs_thr;
            longint       side_thr;
            longint       fwd;
            longint       lat;
            t_scan_result r;
            ch = s.channel;
            sd = $signed(s.side);
            if (s.clear_side) side_seen = 1'b0;
            if (ch == CH_CENTER) begin
                hits    = '0;
                left_q  = '0;
                right_q = '0;
            end
            y = (longint'(FILT_NUM) * longint'(smooth[ch]) + (longint'(s.raw) << FRAC)
                 + (longint'(last_raw[ch]) << FRAC)) >> FILT_SHIFT;
            smooth[ch]   = y[19:0];
            last_raw[ch] = s.raw;
            // thresholds may go negative; compare as signed
            obs_thr  = (longint'(noise) - longint'(s.offset)) * (longint'(1) << FRAC);
            side_thr = (longint'(noise) - longint'(margin)) * (longint'(1) << FRAC);
            if (y > obs_thr) begin
                held[ch] = y[19:0];
                if (ch == CH_CENTER || (ch == CH_FRONT_L && sd <= 0)
                        || (ch == CH_FRONT_R && sd >= 0)) begin
                    ahead = 1'b1;
                    if (hits != COUNT_MAX) hits++;
                end
            end else if (y > side_thr) begin
                if (ch == CH_SIDE_L2 || ch == CH_SIDE_L3 || ch == CH_SIDE_R5
                        || ch == CH_SIDE_R6)
                    side_seen = !ahead;
            end else if (ch == CH_SIDE_R5 || ch == CH_SIDE_R6) begin
                if (right_q != COUNT_MAX) right_q++;
            end else if (ch == CH_SIDE_L2 || ch == CH_SIDE_L3) begin
                if (left_q != COUNT_MAX) left_q++;
            end
            if (y < longint'(clear_lvl) * (longint'(1) << FRAC)) held[ch] = '0;
            if (ch != CH_FRONT_R) return;

            if (hits == 0) ahead = 1'b0;
            if (left_q == QUIET_FULL && right_q == QUIET_FULL) side_seen = 1'b0;
            fwd = -longint'(held[0]) - longint'(held[1] >> 1) - longint'(held[7] >> 1);
            lat = longint'(held[1] >> 1) + longint'(held[2] >> 1) + longint'(held[3] >> 1)
                - longint'(held[5] >> 1) - longint'(held[6] >> 1) - longint'(held[7] >> 1);
            r.pad        = 1'b0;
            r.ahead      = ahead;
            r.side_obs   = side_seen;
            r.turn_right = held[1] > held[7];
            r.forward    = fwd[SUM_BITS-1:0];
            r.lateral    = lat[SUM_BITS-1:0];
            expected_scans.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(logic [OUT_BITS-1:0] bus);
            t_scan_result got;
            t_scan_result want;
            got = bus;
            if (expected_scans.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result %h", $time, bus);
                return;
            end
            want = expected_scans.pop_front();
            results_checked++;
            compare_field("obstacle_ahead", want.ahead, got.ahead);
            compare_field("side_obstacle", want.side_obs, got.side_obs);
            compare_field("turn_right", want.turn_right, got.turn_right);
            compare_field("forward_sum", longint'($signed(want.forward)),
                          longint'($signed(got.forward)));
            compare_field("lateral_sum", longint'($signed(want.lateral)),
                          longint'($signed(got.lateral)));
            compare_field("pad", want.pad, got.pad);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic [IN_W-1:0]     i_s_tdata;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [OUT_BITS-1:0] o_m_tdata;
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    t_level              i_cfg_data;

    t_scan_scoreboard sb = new();
    bit               allow_idle = 1'b1;
    bit               hold_off_req = 1'b0;
    int               n_samples = 0;

    proximity_obstacle_classifier uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("timeout at %0t", $time);
        $display("** proximity_obstacle_classifier: FAILED **");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample make_sample(int ch, int raw, int off, t_side sd, bit clr);
        t_sample s;
        s.channel    = t_chan'(ch);
        s.raw        = SAMPLE_W'(raw);
        s.offset     = t_offset'(off);
        s.side       = sd;
        s.clear_side = clr;
        return s;
    endfunction

    // keep most readings near the current thresholds so every band is reached
    function automatic t_sample random_sample(int ch);
        int r;
        int raw;
        r = $urandom_range(0, 7);
        if (r == 0)      raw = $urandom_range(0, 4095);
        else if (r == 1) raw = $urandom_range(0, int'(sb.clear_lvl) + 3);
        else             raw = $urandom_range(0, 2 * int'(sb.noise) + 16);
        return make_sample(ch, raw, $urandom_range(0, 63), t_side'($urandom_range(0, 3)),
                           $urandom_range(0, 7) == 0);
    endfunction

    task automatic pause_sender(int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic offer_sample(t_sample s);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_sample(s);
        n_samples++;
        if (allow_idle && $urandom_range(0, 9) < 3) pause_sender(idle_length());
    endtask

    // hold until all scan results are back and the pipeline is empty
    task automatic drain_results();
        pause_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, t_level v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_level(idx, v);
    endtask

    task automatic random_burst();
        int r;
        int first;
        r = $urandom_range(0, 9);
        if (r < 8) begin
            for (int c = 0; c < CHANNELS; c++) offer_sample(random_sample(c));
        end else if (r == 8) begin
            // partial scan, some channels dropped
            first = $urandom_range(0, 6);
            for (int c = first; c < CHANNELS; c++)
                if (c == 7 || $urandom_range(0, 3) != 0) offer_sample(random_sample(c));
        end else begin
            repeat ($urandom_range(1, 4)) offer_sample(random_sample($urandom_range(0, 7)));
        end
    endtask

    task automatic directed_samples();
        for (int c = 0; c < CHANNELS; c++)
            offer_sample(make_sample(c, 4095, 0, t_side'(c), 1'b0));
        for (int c = 0; c < CHANNELS; c++)
            offer_sample(make_sample(c, 0, 63, 2'b10, 1'b1));
        // partial scan, then out-of-order channels
        offer_sample(make_sample(0, 300, 25, 2'b00, 1'b0));
        offer_sample(make_sample(2, 300, 25, 2'b00, 1'b0));
        offer_sample(make_sample(7, 300, 25, 2'b00, 1'b0));
        offer_sample(make_sample(7, 60, 5, SIDE_RIGHT, 1'b1));
        offer_sample(make_sample(3, 60, 5, SIDE_RIGHT, 1'b0));
        offer_sample(make_sample(7, 60, 5, 2'b11, 1'b0));
    endtask

    // result side: check accepted results, stall at random
    initial begin : result_sink
        int stall_left;
        bit hold_off_taken;
        stall_left     = 0;
        hold_off_taken = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (hold_off_req && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                stall_left     = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else if (allow_idle && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = idle_length() - 1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_level noise_set  [N_PHASES] = '{8'd50, 8'd0, 8'd255, 8'd255, 8'd20, 8'd0, 8'd50};
        t_level margin_set [N_PHASES] = '{8'd10, 8'd0, 8'd255, 8'd0, 8'd40, 8'd0, 8'd10};
        t_level clear_set  [N_PHASES] = '{8'd5, 8'd0, 8'd255, 8'd255, 8'd30, 8'd0, 8'd5};
        int     target;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_NOISE;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                if (p == 5) begin
                    noise_set[p]  = t_level'($urandom_range(0, 255));
                    margin_set[p] = t_level'($urandom_range(0, 255));
                    clear_set[p]  = t_level'($urandom_range(0, 255));
                end
                write_register(CFG_NOISE, noise_set[p]);
                write_register(CFG_MARGIN, margin_set[p]);
                write_register(CFG_CLEAR, clear_set[p]);
                i_cfg_we <= 1'b0;
            end
            // one phase runs with no idling on either side
            allow_idle = (p != 3);
            if (p == 0) directed_samples();
            if (p == 2) begin
                // long output hold-off while requests keep coming
                allow_idle   = 1'b0;
                hold_off_req = 1'b1;
                repeat (4) random_burst();
                allow_idle = 1'b1;
            end
            target = n_samples + RANDOM_PER_PHASE;
            while (n_samples < target) random_burst();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d samples, %0d scan results, %0d register settings.",
                 n_samples, sb.results_checked, N_PHASES);
        $display("Included output hold-off, idle and no-idle phases; %0d errors.", sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** proximity_obstacle_classifier: PASSED **");
        end else begin
            $display("** proximity_obstacle_classifier: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/poc_pkg.sv
hdl/poc_state_mem.sv
hdl/poc_chan_update.sv
hdl/proximity_obstacle_classifier.sv
tb/sv/proximity_obstacle_classifier_tb.sv
